@@ design/cps_pkg.sv @@
// Package for the CPU process scheduler: field widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package cps_pkg;

  localparam int ID_W    = 5;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int KIND_W  = 2;
  localparam int TICK_W  = 8;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_RR   = 2'd2,
    MODE_SRTN = 2'd3
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAP  = 2'd2;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_SWITCH = 2'd1,
    REG_SLICE  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_PICK,
    S_SCAN,
    S_DECIDE,
    S_POP,
    S_EXEC,
    S_EMIT
  } state_t;

  typedef struct packed {
    mode_t             mode;
    logic [TICK_W-1:0] switch_ticks;
    logic [TICK_W-1:0] slice_ticks;
  } cfg_t;

  typedef struct packed {
    logic arrive;
    logic gap_dec;
    logic park;
    logic scan_clr;
    logic scan_step;
    logic srtn_gap;
    logic take_best;
    logic pop;
    logic take_lowest;
    logic exec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic gap_nz;
    logic run_nz;
    logic slice_z;
    logic best_ne_run;
    logic switch_nz;
    logic scan_last;
    logic fifo_nz;
    logic pop_hit;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ design/cps_datapath.sv @@
// Scheduler datapath: process tables, ready queue, selection scan, tick
// execution and the result register. Uses cps_pkg.
`default_nettype none
module cps_datapath import cps_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire cfg_t               cfg,
  input  wire logic [ID_W-1:0]    in_id,
  input  wire logic [BURST_W-1:0] in_burst,
  input  wire logic [PRIO_W-1:0]  in_prio,
  output stat_t                   stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [KIND_W-1:0]       out_kind,
  output logic [ID_W-1:0]         out_owner,
  output logic                    out_done
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RID_W = $clog2(MAX_PROCS + 1);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  logic [BURST_W-1:0] rem_r  [MAX_PROCS];
  logic [PRIO_W-1:0]  prio_r [MAX_PROCS];
  logic [RID_W-1:0]   fifo_r [MAX_PROCS];
  logic [MAX_PROCS-1:0] valid_r;
  logic [IDX_W-1:0]   head_r;
  logic [CNT_W-1:0]   count_r;
  logic [RID_W-1:0]   run_r;
  logic [TICK_W-1:0]  slice_r;
  logic [TICK_W-1:0]  gap_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic [RID_W-1:0]   best_id_r;
  logic [BURST_W-1:0] best_key_r;
  logic [KIND_W-1:0]  res_kind_r;
  logic [RID_W-1:0]   res_owner_r;
  logic               res_done_r;
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ID_W-1:0]    out_owner_r;
  logic               out_done_r;

  logic               id_ok, arrive_ok, push, fifo_full;
  logic [IDX_W-1:0]   in_idx, run_idx, rd_idx, tail_idx, head_nxt_idx, head_idx;
  logic [CNT_W:0]     tail_sum;
  logic [RID_W-1:0]   head_id, low_id, in_rid;
  logic               head_pend, run_pend, cand;
  logic [BURST_W-1:0] rem_rd, key;
  logic [PRIO_W-1:0]  prio_rd;
  logic [TICK_W-1:0]  slice_init, slice_dec;

  assign id_ok     = (in_id != '0) && (32'(in_id) <= 32'(MAX_PROCS));
  assign in_idx    = IDX_W'(32'(in_id) - 32'd1);
  assign in_rid    = RID_W'(in_id);
  assign arrive_ok = cmd.arrive && id_ok && (in_burst != '0) && !valid_r[in_idx];
  assign fifo_full = (32'(count_r) >= 32'(MAX_PROCS));
  assign push      = ((arrive_ok && (cfg.mode == MODE_FCFS || cfg.mode == MODE_RR))
                     || cmd.park) && !fifo_full;

  // tail slot, wrapped without a divider
  assign tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
  assign tail_idx = (32'(tail_sum) >= 32'(MAX_PROCS)) ?
                    IDX_W'(32'(tail_sum) - 32'(MAX_PROCS)) : IDX_W'(tail_sum);
  assign head_nxt_idx = (32'(head_r) == 32'(MAX_PROCS - 1)) ? '0 : head_r + 1'b1;

  assign head_id   = fifo_r[head_r];
  assign head_idx  = IDX_W'(32'(head_id) - 32'd1);
  assign head_pend = (head_id != '0) && (32'(head_id) <= 32'(MAX_PROCS)) && valid_r[head_idx];

  assign run_idx   = IDX_W'(32'(run_r) - 32'd1);
  assign run_pend  = (run_r != '0) && valid_r[run_idx];

  assign rd_idx  = cmd.exec ? run_idx : scan_idx_r;
  assign rem_rd  = rem_r[rd_idx];
  assign prio_rd = prio_r[rd_idx];

  // SRTN keeps the strictly smaller time, priority mode the last of equal keys
  always_comb begin
    if (cfg.mode == MODE_SRTN) begin
      key  = rem_rd;
      cand = valid_r[scan_idx_r] && ((best_id_r == '0) || (rem_rd < best_key_r));
    end else begin
      key  = BURST_W'(prio_rd);
      cand = valid_r[scan_idx_r] && ((best_id_r == '0) || (key >= best_key_r));
    end
  end

  always_comb begin
    low_id = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (valid_r[i]) low_id = RID_W'(i + 1);
    end
  end

  assign slice_init = (cfg.slice_ticks == '0) ? TICK_W'(1) : cfg.slice_ticks;
  assign slice_dec  = (slice_r == '0) ? '0 : slice_r - 1'b1;

  always_ff @(posedge clk) begin
    if (arrive_ok) begin
      rem_r[in_idx]  <= in_burst;
      prio_r[in_idx] <= in_prio;
    end else if (cmd.exec && run_pend) begin
      rem_r[run_idx] <= rem_rd - 1'b1;
    end
    if (push) begin
      fifo_r[tail_idx] <= cmd.park ? run_r : in_rid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      run_r       <= '0;
      slice_r     <= '0;
      gap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) count_r <= count_r + 1'b1;
      if (arrive_ok) valid_r[in_idx] <= 1'b1;
      if (cmd.gap_dec) gap_r <= gap_r - 1'b1;
      if (cmd.park) run_r <= '0;
      if (cmd.srtn_gap) begin
        run_r <= '0;
        gap_r <= cfg.switch_ticks - 1'b1;
      end
      if (cmd.take_best) begin
        run_r <= best_id_r;
        if (cfg.mode != MODE_SRTN) slice_r <= slice_init;
      end
      if (cmd.pop) begin
        head_r  <= head_nxt_idx;
        count_r <= count_r - 1'b1;
        if (head_pend && head_id != run_r) begin
          run_r   <= head_id;
          slice_r <= slice_init;
        end
      end
      if (cmd.take_lowest) begin
        run_r   <= low_id;
        slice_r <= slice_init;
      end
      if (cmd.exec) begin
        if (!run_pend) begin
          run_r <= '0;
        end else if (rem_rd == BURST_W'(1)) begin
          valid_r[run_idx] <= 1'b0;
          run_r            <= '0;
          gap_r            <= cfg.switch_ticks;
        end else if (cfg.mode == MODE_RR) begin
          slice_r <= slice_dec;
          if (slice_dec == '0) gap_r <= cfg.switch_ticks;
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // scan and result registers: payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx_r <= '0;
      best_id_r  <= '0;
      best_key_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (cand) begin
        best_id_r  <= RID_W'(32'(scan_idx_r) + 32'd1);
        best_key_r <= key;
      end
    end
    if (cmd.gap_dec || cmd.srtn_gap) begin
      res_kind_r  <= KIND_GAP;
      res_owner_r <= '0;
      res_done_r  <= 1'b0;
    end else if (cmd.exec) begin
      res_kind_r  <= run_pend ? KIND_RUN : KIND_IDLE;
      res_owner_r <= run_pend ? run_r : '0;
      res_done_r  <= run_pend && (rem_rd == BURST_W'(1));
    end
    if (cmd.out_load) begin
      out_kind_r  <= res_kind_r;
      out_owner_r <= ID_W'(res_owner_r);
      out_done_r  <= res_done_r;
    end
  end

  always_comb begin
    stat.gap_nz      = (gap_r != '0);
    stat.run_nz      = (run_r != '0);
    stat.slice_z     = (slice_r == '0);
    stat.best_ne_run = (best_id_r != run_r);
    stat.switch_nz   = (cfg.switch_ticks != '0);
    stat.scan_last   = (32'(scan_idx_r) == 32'(MAX_PROCS - 1));
    stat.fifo_nz     = (count_r != '0);
    stat.pop_hit     = head_pend && (head_id != run_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_owner = out_owner_r;
  assign out_done  = out_done_r;

endmodule
`default_nettype wire

@@ design/cps_ctrl.sv @@
// Scheduler controller: sequences one arrival or tick through the datapath
// by command and status structs. Uses cps_pkg.
`default_nettype none
module cps_ctrl import cps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_action,
  output logic       in_ready,
  input  wire mode_t mode,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid && in_action == ACT_TICK) state_nxt = S_TICK;
      S_TICK: begin
        if (stat.gap_nz)            state_nxt = S_EMIT;
        else if (mode == MODE_SRTN) state_nxt = S_SCAN;
        else                        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.run_nz)            state_nxt = S_EXEC;
        else if (mode == MODE_PRIO) state_nxt = S_SCAN;
        else                        state_nxt = S_POP;
      end
      S_SCAN:   if (stat.scan_last) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (mode == MODE_SRTN && stat.run_nz && stat.best_ne_run && stat.switch_nz)
          state_nxt = S_EMIT;
        else
          state_nxt = S_EXEC;
      end
      S_POP:    if (!stat.fifo_nz || stat.pop_hit) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_EMIT;
      S_EMIT:   if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.arrive = in_valid && in_action == ACT_ARRIVE;
      end
      S_TICK: begin
        cmd.gap_dec  = stat.gap_nz;
        cmd.scan_clr = !stat.gap_nz && mode == MODE_SRTN;
        cmd.park     = !stat.gap_nz && mode == MODE_RR && stat.run_nz && stat.slice_z;
      end
      S_PICK:   cmd.scan_clr = !stat.run_nz && mode == MODE_PRIO;
      S_SCAN:   cmd.scan_step = 1'b1;
      S_DECIDE: begin
        if (mode == MODE_SRTN && stat.run_nz && stat.best_ne_run && stat.switch_nz)
          cmd.srtn_gap = 1'b1;
        else
          cmd.take_best = 1'b1;
      end
      S_POP: begin
        cmd.pop         = stat.fifo_nz;
        cmd.take_lowest = !stat.fifo_nz;
      end
      S_EXEC:   cmd.exec = 1'b1;
      S_EMIT:   cmd.out_load = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/cpu_process_scheduler_unit.sv @@
// Arrival: taken in the idle state. A tick runs from TICK to EMIT: directly in a gap;
// through PICK and EXEC with a job already running; through PICK, POP and EXEC when the
// ready queue is popped, staying in POP while stale entries drain (one pop a cycle); for
// SRTN through the SCAN of all MAX_PROCS slots, DECIDE and EXEC, or DECIDE alone for a
// switch gap; for priority through PICK, SCAN, DECIDE and EXEC. A stalled result adds its stall.
// Synchronous active-low reset clears the control state and the configuration registers.
// Uses cps_pkg, cps_ctrl and cps_datapath.
`default_nettype none
module cpu_process_scheduler_unit import cps_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // proc_id[4:0], burst_len[20:5], prio_level[28:21]
  input  wire logic        in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // tick_owner[4:0], job_done[5]
  output logic [1:0]       out_tuser, // tick_kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t     cfg_r;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_t reg_sel;
  logic [ID_W-1:0] owner;
  logic            done;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= MODE_FCFS;
      cfg_r.switch_ticks <= '0;
      cfg_r.slice_ticks  <= TICK_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        REG_MODE:   cfg_r.mode         <= mode_t'(cfg_pwdata[1:0]);
        REG_SWITCH: cfg_r.switch_ticks <= cfg_pwdata[7:0];
        REG_SLICE:  cfg_r.slice_ticks  <= cfg_pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:   cfg_prdata = {30'd0, cfg_r.mode};
      REG_SWITCH: cfg_prdata = {24'd0, cfg_r.switch_ticks};
      REG_SLICE:  cfg_prdata = {24'd0, cfg_r.slice_ticks};
      default:    cfg_prdata = '0;
    endcase
  end

  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .mode      (cfg_r.mode),
    .stat      (stat),
    .cmd       (cmd)
  );

  cps_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_id     (in_tdata[4:0]),
    .in_burst  (in_tdata[20:5]),
    .in_prio   (in_tdata[28:21]),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_owner (owner),
    .out_done  (done)
  );

  assign out_tdata = {2'b00, done, owner};

endmodule
`default_nettype wire

@@ dv/sched_checker.sv @@
// Checker for cpu_process_scheduler_unit: watches the input, result and APB channels, keeps
// its own copy of the scheduler state, and compares each result transfer field by field.
// Depends on cps_pkg.
module sched_checker import cps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               err_count,
  output int               tick_backlog
);

  localparam int NPROC = 16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   owner;
    logic              done;
  } tick_res_t;

  tick_res_t tick_q[$];

  logic [BURST_W-1:0] rem_ticks [1:NPROC];
  logic [PRIO_W-1:0]  prio_of   [1:NPROC];
  bit                 live      [1:NPROC];
  int                 ready_q   [0:NPROC-1];
  int                 q_head, q_cnt, run_id, slice_cnt, gap_cnt;
  mode_t              mode_r;
  int                 switch_r, slice_r;

  function automatic bit is_live(int id);
    return id >= 1 && id <= NPROC && live[id];
  endfunction

  task automatic q_push(int id);
    if (q_cnt < NPROC) begin
      ready_q[(q_head + q_cnt) % NPROC] = id;
      q_cnt++;
    end
  endtask

  // stale entries (finished, or the job on the CPU) are dropped on the way out
  task automatic q_pop(output int id);
    int cand;
    id = 0;
    while (q_cnt > 0) begin
      cand = ready_q[q_head];
      q_head = (q_head + 1) % NPROC;
      q_cnt--;
      if (is_live(cand) && cand != run_id) begin
        id = cand;
        return;
      end
    end
  endtask

  task automatic sched_tick(output tick_res_t r);
    int best;
    r = '0;
    if (gap_cnt > 0) begin
      gap_cnt--;
      r.kind = KIND_GAP;
      return;
    end
    if (mode_r == MODE_SRTN) begin
      best = 0;
      for (int i = 1; i <= NPROC; i++)
        if (live[i] && (best == 0 || rem_ticks[i] < rem_ticks[best])) best = i;
      if (run_id != 0 && best != run_id && switch_r > 0) begin
        run_id  = 0;
        gap_cnt = switch_r - 1;
        r.kind  = KIND_GAP;
        return;
      end
      run_id = best;
    end else begin
      if (run_id != 0 && mode_r == MODE_RR && slice_cnt == 0) begin
        // quantum expired: requeued only now, behind arrivals made during the gap
        q_push(run_id);
        run_id = 0;
      end
      if (run_id == 0) begin
        if (mode_r == MODE_PRIO) begin
          for (int i = 1; i <= NPROC; i++)
            if (live[i] && (run_id == 0 || prio_of[i] >= prio_of[run_id])) run_id = i;
        end else begin
          q_pop(run_id);
          if (run_id == 0)
            for (int i = NPROC; i >= 1; i--) if (live[i]) run_id = i;
        end
        slice_cnt = slice_r != 0 ? slice_r : 1;
      end
    end
    if (!is_live(run_id)) begin
      run_id = 0;
      return;
    end
    r.kind  = KIND_RUN;
    r.owner = ID_W'(run_id);
    rem_ticks[run_id]--;
    if (rem_ticks[run_id] == 0) begin
      r.done       = 1'b1;
      live[run_id] = 0;
      run_id       = 0;
      gap_cnt      = switch_r;
    end else if (mode_r == MODE_RR) begin
      if (slice_cnt > 0) slice_cnt--;
      if (slice_cnt == 0) gap_cnt = switch_r;
    end
  endtask

  task automatic sched_arrive(int id, logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] pr);
    if (id < 1 || id > NPROC || burst == 0 || live[id]) return;
    rem_ticks[id] = burst;
    prio_of[id]   = pr;
    live[id]      = 1;
    if (mode_r == MODE_FCFS || mode_r == MODE_RR) q_push(id);
  endtask

  assign tick_backlog = tick_q.size();

  always @(posedge clk) begin
    tick_res_t got, want;
    if (!rst_n) begin
      tick_q.delete();
      for (int i = 1; i <= NPROC; i++) live[i] = 0;
      q_head = 0; q_cnt = 0; run_id = 0; slice_cnt = 0; gap_cnt = 0;
      mode_r = MODE_FCFS; switch_r = 0; slice_r = 1;
      err_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, owner: out_tdata[4:0], done: out_tdata[5]};
        if (tick_q.size() == 0) begin
          $display("%0t: unexpected result transfer kind=%0d owner=%0d done=%0d",
                   $time, got.kind, got.owner, got.done);
          err_count <= err_count + 1;
        end else begin
          want = tick_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected kind=%0d owner=%0d done=%0d, got kind=%0d owner=%0d done=%0d",
                     $time, want.kind, want.owner, want.done, got.kind, got.owner, got.done);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_TICK) begin
          sched_tick(want);
          tick_q.push_back(want);
        end else begin
          sched_arrive(int'(in_tdata[4:0]), in_tdata[20:5], in_tdata[28:21]);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_MODE:   mode_r   = mode_t'(cfg_pwdata[1:0]);
          REG_SWITCH: switch_r = int'(cfg_pwdata[7:0]);
          REG_SLICE:  slice_r  = int'(cfg_pwdata[7:0]);
          default: ;
        endcase
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Top of the scheduler testbench: clock, reset, APB register writes, bursty input
// stimulus and a stalling receiver. Depends on cps_pkg, sched_checker and the RTL.
module tb_top;
  import cps_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // proc_id[4:0], burst_len[20:5], prio_level[28:21]
  logic        in_tuser = 0;   // action
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [7:0]  out_tdata;      // tick_owner[4:0], job_done[5]
  logic [1:0]  out_tuser;      // tick_kind
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          err_count, tick_backlog;
  int          burst_left = 0;
  int          stall_kind = 0, stall_cnt = 0;

  cpu_process_scheduler_unit u_dut (.*);
  sched_checker u_chk (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: one of four stall patterns, redrawn at random, one of them never stalling
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_kind <= $urandom_range(3);
    case (stall_kind)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(1);
      2:       out_tready <= (stall_cnt % 4 == 0);
      default: out_tready <= ($urandom_range(9) != 0);
    endcase
  end

  task automatic push_item(logic act, logic [31:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic arrive(int id, int burst, int pr);
    push_item(ACT_ARRIVE, {3'b0, pr[7:0], burst[15:0], id[4:0]});
  endtask

  task automatic tick();
    push_item(ACT_TICK, $urandom);
  endtask

  // waits until every tick has been answered and any trailing arrival has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tick_backlog != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_policy(mode_t m, int sw, int sl);
    drain();
    reg_write(REG_MODE, 32'(m));
    reg_write(REG_SWITCH, sw);
    reg_write(REG_SLICE, sl);
  endtask

  task automatic rand_items(int n);
    int k, id;
    repeat (n) begin
      if ($urandom_range(99) < 55) begin
        tick();
      end else begin
        k = $urandom_range(19);
        if (k == 0) begin
          // bad id with a full-range burst keeps the upper burst bits exercised
          id = $urandom_range(1) ? 0 : $urandom_range(31, 17);
          arrive(id, $urandom, $urandom);
        end else if (k == 1) begin
          arrive($urandom_range(1, 16), 0, $urandom);
        end else begin
          arrive($urandom_range(1, 16), $urandom_range(1, 10), $urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset policy: first come first served, no gap, quantum of one
    arrive(1, 1, 0);
    arrive(16, 3, 255);
    arrive(0, 65535, 255);
    arrive(31, 65535, 0);
    arrive(2, 0, 7);
    arrive(16, 5, 1);
    arrive(2, 20, 9);
    repeat (6) tick();
    // priority ties go to the larger id; a bogus register index is ignored
    set_policy(MODE_PRIO, 1, 0);
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    arrive(3, 2, 128);
    arrive(5, 2, 128);
    repeat (12) tick();

    set_policy(MODE_RR,   1,   3);   rand_items(250);
    set_policy(MODE_SRTN, 0,   1);   rand_items(200);
    set_policy(MODE_SRTN, 3,   1);   rand_items(250);
    set_policy(MODE_RR,   0,   255); rand_items(200);
    set_policy(MODE_FCFS, 255, 1);   rand_items(150);
    set_policy(MODE_PRIO, 0,   5);   rand_items(200);
    set_policy(MODE_RR,   2,   1);   rand_items(250);
    set_policy(MODE_RR,   0,   0);   rand_items(150);
    set_policy(MODE_FCFS, 1,   2);   rand_items(200);
    set_policy(MODE_SRTN, 255, 1);   rand_items(150);
    drain();

    if (err_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
